### rtl/hbrd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hbrd_pkg: shared types and constants of the hex / base64 region decoder
// Item and result words, the classified word between front and back, and
// the operation, result kind and region mode codes.
// ----------------------------------------------------------------------------
package hbrd_pkg;

  // Input operation codes
  typedef enum logic [1:0] {
    OP_CHAR = 2'd0,
    OP_HEX  = 2'd1,
    OP_B64  = 2'd2,
    OP_EOF  = 2'd3
  } op_e;

  // Result kinds
  typedef enum logic [1:0] {
    KIND_DATA = 2'd0,
    KIND_TERM = 2'd1,
    KIND_EOF  = 2'd2,
    KIND_ERR  = 2'd3
  } kind_e;

  // Region mode, one-hot
  typedef enum logic [2:0] {
    MODE_PASS = 3'b001,
    MODE_HEX  = 3'b010,
    MODE_B64  = 3'b100
  } mode_e;

  // Character constants
  localparam logic [7:0] CH_HASH  = 8'h23;  // '#'
  localparam logic [7:0] CH_BAR   = 8'h7C;  // '|'
  localparam logic [7:0] CH_BRACE = 8'h7D;  // '}'
  localparam logic [7:0] CH_EQ    = 8'h3D;  // '='

  // Digit widths and byte size
  localparam logic [4:0] HEX_BITS  = 5'd4;
  localparam logic [4:0] B64_BITS  = 5'd6;
  localparam logic [4:0] BYTE_BITS = 5'd8;

  typedef struct packed {
    op_e        op;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    kind_e      kind;
    logic       leftover_warning;
    logic       bad_char;
  } out_item_t;

  // Mode-independent classification of one input word
  typedef struct packed {
    op_e        op;
    logic [7:0] ch;
    logic       is_space;
    logic       is_hash;
    logic       is_bar;
    logic       is_eq;
    logic       hex_ok;
    logic [3:0] hex_val;
    logic       b64_ok;
    logic [5:0] b64_val;
  } class_t;

endpackage
`default_nettype wire

### rtl/hbrd_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hbrd_front: input side of the region decoder
// Classifies each accepted word for both digit alphabets and holds it in a
// two-entry queue until the back end takes it.
// ----------------------------------------------------------------------------
module hbrd_front (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  output logic                   full,
  input  wire hbrd_pkg::in_item_t item,
  output logic                   cls_valid,
  input  wire logic              cls_pop,
  output hbrd_pkg::class_t       cls
);
  import hbrd_pkg::*;

  class_t     cls_in;
  logic [7:0] c;
  class_t     mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       wr_en;
  logic       rd_en;

  // Classify the incoming character for every mode at once
  always_comb begin
    c              = item.data_byte;
    cls_in.op      = item.op;
    cls_in.ch      = c;
    cls_in.is_space = (c == 8'h20) || (c inside {[8'h09:8'h0D]});
    cls_in.is_hash = (c == CH_HASH);
    cls_in.is_bar  = (c == CH_BAR) || (c == CH_BRACE);
    cls_in.is_eq   = (c == CH_EQ);
    cls_in.hex_ok  = 1'b1;
    cls_in.hex_val = 4'd0;
    if (c inside {[8'h30:8'h39]}) begin
      cls_in.hex_val = 4'(c - 8'h30);
    end else if (c inside {[8'h41:8'h46]}) begin
      cls_in.hex_val = 4'(c - 8'h37);
    end else if (c inside {[8'h61:8'h66]}) begin
      cls_in.hex_val = 4'(c - 8'h57);
    end else begin
      cls_in.hex_ok = 1'b0;
    end
    cls_in.b64_ok  = 1'b1;
    cls_in.b64_val = 6'd0;
    if (c inside {[8'h41:8'h5A]}) begin
      cls_in.b64_val = 6'(c - 8'h41);
    end else if (c inside {[8'h61:8'h7A]}) begin
      cls_in.b64_val = 6'(c - 8'h47);
    end else if (c inside {[8'h30:8'h39]}) begin
      cls_in.b64_val = 6'(c + 8'h04);
    end else if (c == 8'h2B) begin
      cls_in.b64_val = 6'd62;
    end else if (c == 8'h2F) begin
      cls_in.b64_val = 6'd63;
    end else begin
      cls_in.b64_ok = 1'b0;
    end
  end

  // Queue handshake
  assign full      = (count == 2'd2);
  assign cls_valid = (count != 2'd0);
  assign wr_en     = push && !full;
  assign rd_en     = cls_pop && cls_valid;
  assign cls       = mem[rd_ptr];

  // Store classified words
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= cls_in;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (wr_en) begin
        wr_ptr <= !wr_ptr;
      end
      if (rd_en) begin
        rd_ptr <= !rd_ptr;
      end
      count <= 2'(count + {1'b0, wr_en} - {1'b0, rd_en});
    end
  end

  a_count_max: assert property (@(posedge clk) disable iff (rst) count <= 2'd2)
    else $error("front queue overfilled");
  a_ptr_gap: assert property (@(posedge clk) disable iff (rst)
    (count == 2'd0 || count == 2'd2) |-> (wr_ptr == rd_ptr))
    else $error("front queue pointers out of step");
  a_full_holds: assert property (@(posedge clk) disable iff (rst)
    (full && !rd_en) |=> full)
    else $error("front queue lost a word while stalled");

endmodule
`default_nettype wire

### rtl/hbrd_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hbrd_back: execution side of the region decoder
// Keeps the region mode and bit accumulator, turns classified words into
// result words and holds them in a two-entry output queue.
// ----------------------------------------------------------------------------
module hbrd_back (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cls_valid,
  output logic                   cls_pop,
  input  wire hbrd_pkg::class_t  cls,
  output logic                   empty,
  input  wire logic              pop,
  output hbrd_pkg::out_item_t    result
);
  import hbrd_pkg::*;

  mode_e      mode;
  mode_e      mode_next;
  logic [15:0] bit_buffer;
  logic [15:0] bit_buffer_next;
  logic [3:0]  bit_count;
  logic [3:0]  bit_count_next;

  logic        go;
  logic        res_valid;
  out_item_t   res;
  logic        in_hex;
  logic        term;
  logic        bad;
  logic [15:0] acc;
  logic [4:0]  sum;
  logic [15:0] mask;

  out_item_t   mem [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  count;
  logic        out_full;
  logic        wr_en;
  logic        rd_en;

  // Take a word whenever the output queue has room
  assign out_full = (count == 2'd2);
  assign go       = cls_valid && !out_full;
  assign cls_pop  = go;

  // Decode one word against the current mode
  always_comb begin
    mode_next       = mode;
    bit_buffer_next = bit_buffer;
    bit_count_next  = bit_count;
    res_valid       = 1'b0;
    res             = '0;
    in_hex          = (mode == MODE_HEX);
    term            = in_hex ? cls.is_hash : cls.is_bar;
    bad             = 1'b0;
    acc             = 16'd0;
    sum             = 5'd0;
    mask            = ~(16'hFFFF << bit_count);
    if (go) begin
      case (cls.op)
        OP_HEX: begin
          mode_next       = MODE_HEX;
          bit_buffer_next = 16'd0;
          bit_count_next  = 4'd0;
        end
        OP_B64: begin
          mode_next       = MODE_B64;
          bit_buffer_next = 16'd0;
          bit_count_next  = 4'd0;
        end
        OP_EOF: begin
          mode_next       = MODE_PASS;
          bit_buffer_next = 16'd0;
          bit_count_next  = 4'd0;
          res_valid       = 1'b1;
          res.kind        = KIND_EOF;
        end
        default: begin
          if (mode == MODE_HEX || mode == MODE_B64) begin
            if (term) begin
              // Close the region, flag unused nonzero bits
              res_valid            = 1'b1;
              res.out_byte         = cls.ch;
              res.kind             = KIND_TERM;
              res.leftover_warning = (bit_count != 4'd0) && ((bit_buffer & mask) != 16'd0);
              mode_next            = MODE_PASS;
              bit_buffer_next      = 16'd0;
              bit_count_next       = 4'd0;
            end else if (cls.is_space || (!in_hex && cls.is_eq)) begin
              // Skip filler characters
              res_valid = 1'b0;
            end else begin
              // Shift the digit in, a bad digit counts as zero
              if (in_hex) begin
                bad = !cls.hex_ok;
                acc = {bit_buffer[11:0], cls.hex_ok ? cls.hex_val : 4'd0};
                sum = {1'b0, bit_count} + HEX_BITS;
              end else begin
                bad = !cls.b64_ok;
                acc = {bit_buffer[9:0], cls.b64_ok ? cls.b64_val : 6'd0};
                sum = {1'b0, bit_count} + B64_BITS;
              end
              bit_buffer_next = acc;
              if (sum >= BYTE_BITS) begin
                bit_count_next = 4'(sum - BYTE_BITS);
                res_valid      = 1'b1;
                res.out_byte   = 8'(acc >> (sum - BYTE_BITS));
                res.kind       = KIND_DATA;
                res.bad_char   = bad;
              end else begin
                bit_count_next = sum[3:0];
                if (bad) begin
                  res_valid    = 1'b1;
                  res.kind     = KIND_ERR;
                  res.bad_char = 1'b1;
                end
              end
            end
          end else begin
            // Pass the byte through
            res_valid    = 1'b1;
            res.out_byte = cls.ch;
            res.kind     = KIND_DATA;
          end
        end
      endcase
    end
  end

  // Hold decoder state
  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= MODE_PASS;
      bit_buffer <= 16'd0;
      bit_count  <= 4'd0;
    end else begin
      mode       <= mode_next;
      bit_buffer <= bit_buffer_next;
      bit_count  <= bit_count_next;
    end
  end

  // Output queue handshake
  assign wr_en  = go && res_valid;
  assign rd_en  = pop && !empty;
  assign empty  = (count == 2'd0);
  assign result = mem[rd_ptr];

  // Store result words
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= res;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (wr_en) begin
        wr_ptr <= !wr_ptr;
      end
      if (rd_en) begin
        rd_ptr <= !rd_ptr;
      end
      count <= 2'(count + {1'b0, wr_en} - {1'b0, rd_en});
    end
  end

  a_count_below_byte: assert property (@(posedge clk) disable iff (rst)
    bit_count < 4'd8)
    else $error("accumulator holds a whole byte");
  a_eof_clears: assert property (@(posedge clk) disable iff (rst)
    (go && cls.op == OP_EOF) |=> (mode == MODE_PASS && bit_count == 4'd0 && !empty))
    else $error("end of file did not reset the decoder");
  a_no_overfill: assert property (@(posedge clk) disable iff (rst)
    out_full |-> !wr_en)
    else $error("result written into a full queue");
  a_pass_empty_acc: assert property (@(posedge clk) disable iff (rst)
    (mode == MODE_PASS) |-> (bit_count == 4'd0))
    else $error("accumulator not clear in pass-through");

endmodule
`default_nettype wire

### rtl/hex_base64_region_decoder_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hex_base64_region_decoder_top: hex and base64 region decoder
// Passes characters through, or decodes hex / base64 regions into bytes.
//
//   channel  | handshake    | word
//   ---------+--------------+-------------------------------------------
//   input    | push / full  | item   : op, data_byte
//   result   | pop / empty  | result : out_byte, kind, leftover_warning,
//            |              |          bad_char
//
// One word per cycle sustained while the result side keeps popping; a word
// taken is held in the front queue, then decoded into the result queue once
// the back end takes it (stalled while the result queue is full).
// The combinational decode step in the back end sets the rate.
// Synchronous reset returns to pass-through with an empty accumulator and
// both queues empty. A stalled result side fills the two-entry queues and
// then raises full.
// ----------------------------------------------------------------------------
module hex_base64_region_decoder_top (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 push,
  output logic                      full,
  input  wire hbrd_pkg::in_item_t   item,
  output logic                      empty,
  input  wire logic                 pop,
  output hbrd_pkg::out_item_t       result
);
  import hbrd_pkg::*;

  class_t cls;
  logic   cls_valid;
  logic   cls_pop;

  hbrd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .item      (item),
    .cls_valid (cls_valid),
    .cls_pop   (cls_pop),
    .cls       (cls)
  );

  hbrd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cls_valid (cls_valid),
    .cls_pop   (cls_pop),
    .cls       (cls),
    .empty     (empty),
    .pop       (pop),
    .result    (result)
  );

endmodule
`default_nettype wire

### sim/region_check_pkg.sv
// ----------------------------------------------------------------------------
// region_check_pkg: result prediction and checking for the region decoder
// Tracks the decoder's mode and bit accumulator for every accepted input
// word, queues the result word each one should produce, and compares the
// words that come out against that queue, oldest first.
// ----------------------------------------------------------------------------
package region_check_pkg;

  import hbrd_pkg::*;

  class region_decode_scoreboard;

    mode_e       mode;
    logic [15:0] bit_buf;
    logic [3:0]  bit_cnt;
    out_item_t   expected_words[$];
    int          items_noted;
    int          mismatches;

    function new();
      open_region(MODE_PASS);
      items_noted = 0;
      mismatches = 0;
    endfunction

    // Switch mode and clear the accumulator
    function void open_region(mode_e m);
      mode = m;
      bit_buf = '0;
      bit_cnt = '0;
    endfunction

    function void add_word(logic [7:0] b, kind_e k, logic warn, logic bad);
      out_item_t w;
      w.out_byte = b;
      w.kind = k;
      w.leftover_warning = warn;
      w.bad_char = bad;
      expected_words.push_back(w);
    endfunction

    // Digit value in the current region, or -1 for a non-digit
    function int digit_value(mode_e m, logic [7:0] c);
      int ci;
      ci = int'(c);
      if (m == MODE_HEX) begin
        if (ci >= 48 && ci <= 57) return ci - 48;
        if (ci >= 65 && ci <= 70) return ci - 65 + 10;
        if (ci >= 97 && ci <= 102) return ci - 97 + 10;
        return -1;
      end
      if (ci >= 65 && ci <= 90) return ci - 65;
      if (ci >= 97 && ci <= 122) return ci - 97 + 26;
      if (ci >= 48 && ci <= 57) return ci - 48 + 52;
      if (c == "+") return 62;
      if (c == "/") return 63;
      return -1;
    endfunction

    // Advance the model by one accepted input word
    function void note_item(in_item_t it);
      logic [7:0]  c;
      logic [15:0] mask;
      logic        warn;
      logic        bad;
      int          width;
      int          v;
      int          cnt;
      c = it.data_byte;
      items_noted++;
      case (it.op)
        OP_HEX: begin
          open_region(MODE_HEX);
          return;
        end
        OP_B64: begin
          open_region(MODE_B64);
          return;
        end
        OP_EOF: begin
          open_region(MODE_PASS);
          add_word(8'h00, KIND_EOF, 1'b0, 1'b0);
          return;
        end
        default: ;
      endcase

      // Pass-through: byte goes out unchanged
      if (mode != MODE_HEX && mode != MODE_B64) begin
        add_word(c, KIND_DATA, 1'b0, 1'b0);
        return;
      end

      // Terminator: flag nonzero unused bits, return to pass-through
      if ((mode == MODE_B64 && (c == CH_BAR || c == CH_BRACE)) ||
          (mode == MODE_HEX && c == CH_HASH)) begin
        mask = (16'd1 << bit_cnt) - 16'd1;
        warn = (bit_cnt != 4'd0) && ((bit_buf & mask) != 16'd0);
        open_region(MODE_PASS);
        add_word(c, KIND_TERM, warn, 1'b0);
        return;
      end

      // Drop white space, and padding in base64
      if (c == 8'h20 || c == 8'h09 || c == 8'h0A || c == 8'h0B ||
          c == 8'h0C || c == 8'h0D)
        return;
      if (mode == MODE_B64 && c == CH_EQ) return;

      // Shift the digit in, a non-digit counts as zero
      width = (mode == MODE_HEX) ? 4 : 6;
      v = digit_value(mode, c);
      bad = (v < 0);
      bit_buf = (bit_buf << width) | (bad ? 16'd0 : 16'(v));
      cnt = int'(bit_cnt) + width;
      if (cnt >= 8) begin
        bit_cnt = 4'(cnt - 8);
        add_word(8'(bit_buf >> (cnt - 8)), KIND_DATA, 1'b0, bad);
        return;
      end
      bit_cnt = 4'(cnt);
      if (bad) add_word(8'h00, KIND_ERR, 1'b0, 1'b1);
    endfunction

    function void check_field(string name, int want, int got);
      if (want != got) begin
        $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
        mismatches++;
      end
    endfunction

    // Compare one result word with the oldest prediction
    function void check_result(out_item_t got);
      out_item_t want;
      if (expected_words.size() == 0) begin
        $display("%0t: unexpected result word: expected none, actual %0h", $time, got);
        mismatches++;
        return;
      end
      want = expected_words.pop_front();
      check_field("out_byte", want.out_byte, got.out_byte);
      check_field("kind", want.kind, got.kind);
      check_field("leftover_warning", want.leftover_warning, got.leftover_warning);
      check_field("bad_char", want.bad_char, got.bad_char);
    endfunction

    function int pending();
      return expected_words.size();
    endfunction

  endclass

endpackage

### sim/hex_base64_region_decoder_top_tb.sv
// ----------------------------------------------------------------------------
// hex_base64_region_decoder_top_tb: self-checking bench for the decoder
// Sends directed words covering pass-through, both regions, skipped
// characters, bad digits, terminators and end of file, then random regions
// with random content and noise, with random idle cycles on both sides.
// Every result word is checked against a running prediction.
// ----------------------------------------------------------------------------
module hex_base64_region_decoder_top_tb;

  timeunit 1ns;
  timeprecision 1ps;

  import hbrd_pkg::*;
  import region_check_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int RANDOM_WORDS = 400;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                push = 1'b0;
  logic                pop = 1'b0;
  in_item_t            item = '0;
  logic                full;
  logic                empty;
  out_item_t           result;
  logic                no_idle = 1'b0;
  int                  stall_cycles = 0;

  region_decode_scoreboard sb = new();

  string hex_digits = "0123456789abcdefABCDEF";
  string b64_digits = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
  string space_chars = " \t\n\v\f\r";

  hex_base64_region_decoder_top dut (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .full   (full),
    .item   (item),
    .empty  (empty),
    .pop    (pop),
    .result (result)
  );

  always #6 clk = ~clk;

  // Send one input word and wait until it is taken
  task automatic send_item(op_e op, logic [7:0] b);
    in_item_t it;
    it.op = op;
    it.data_byte = b;
    if (!no_idle) begin
      while ($urandom_range(0, 99) < 9) begin
        push <= 1'b0;
        @(posedge clk);
      end
    end
    push <= 1'b1;
    item <= it;
    do @(posedge clk); while (full);
    sb.note_item(it);
  endtask

  task automatic send_char(logic [7:0] c);
    send_item(OP_CHAR, c);
  endtask

  // One random region with random content, or a burst of noise
  task automatic send_sequence();
    int  n;
    int  p;
    logic is_hex;
    if ($urandom_range(0, 99) < 15) begin
      n = $urandom_range(1, 4);
      repeat (n) begin
        if ($urandom_range(0, 99) < 20) send_item(OP_EOF, 8'($urandom_range(0, 255)));
        else send_char(8'($urandom_range(0, 255)));
      end
      return;
    end
    is_hex = 1'($urandom_range(0, 1));
    send_item(is_hex ? OP_HEX : OP_B64, 8'($urandom_range(0, 255)));
    n = $urandom_range(0, 12);
    repeat (n) begin
      p = $urandom_range(0, 99);
      if (p < 8)
        send_char(space_chars[$urandom_range(0, space_chars.len() - 1)]);
      else if (p < 12 && !is_hex)
        send_char(CH_EQ);
      else if (p < 16)
        send_char(8'($urandom_range(0, 255)));
      else if (is_hex)
        send_char(hex_digits[$urandom_range(0, hex_digits.len() - 1)]);
      else
        send_char(b64_digits[$urandom_range(0, b64_digits.len() - 1)]);
    end
    // Close the region, mostly with its terminator
    p = $urandom_range(0, 99);
    if (p < 80) begin
      if (is_hex) send_char(CH_HASH);
      else send_char($urandom_range(0, 1) ? CH_BAR : CH_BRACE);
    end else if (p < 90) begin
      send_item(OP_EOF, 8'($urandom_range(0, 255)));
    end
  endtask

  // Take and check result words, pop idles at random
  always @(posedge clk) begin
    if (!rst && pop && !empty) sb.check_result(result);
    pop <= no_idle ? 1'b1 : ($urandom_range(0, 99) >= 9);
  end

  // Hang detection: count cycles with no word moving on either side
  always @(posedge clk) begin
    if ((push && !full) || (pop && !empty)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles == STALL_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Pass-through extremes
    send_char(8'h00);
    send_char(8'hFF);
    // Hex region: digits, space, bad digit, leftover bits at the terminator
    send_item(OP_HEX, 8'hFF);
    send_char("4");
    send_char("1");
    send_char(" ");
    send_char("g");
    send_char("7");
    send_char("c");
    send_char(CH_HASH);
    // Base64 region: top digits, padding, hex terminator as a bad digit
    send_item(OP_B64, 8'h00);
    send_char("/");
    send_char("+");
    send_char(CH_EQ);
    send_char("z");
    send_char(CH_HASH);
    send_char(CH_BAR);
    // Re-enter while open, bad terminator, end of file inside a region
    send_item(OP_B64, 8'hA5);
    send_char("9");
    send_item(OP_HEX, 8'h5A);
    send_char("0");
    send_char(CH_BRACE);
    send_item(OP_EOF, 8'hFF);
    send_item(OP_B64, 8'h00);
    send_char("Q");
    send_char(CH_BRACE);
    send_item(OP_EOF, 8'h00);

    // Random regions, with a stretch of no idling in the middle
    while (sb.items_noted < RANDOM_WORDS) begin
      no_idle <= (sb.items_noted > 150 && sb.items_noted < 250);
      send_sequence();
    end
    push <= 1'b0;
    no_idle <= 1'b0;

    // Drain, then keep watching for stray words before reporting
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (sb.mismatches == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule
